[hw/rtl/cfs_pkg.sv]
`timescale 1ns / 1ps

package cfs_pkg;

  localparam int unsigned SpaceHoldDepthDef = 15;
  // Held whitespace store never exceeds this many slots (fits the 4-bit count)
  localparam int unsigned HoldSlots = 15;
  localparam int unsigned HoldCntW  = 4;

  localparam logic [7:0] QuoteByte = 8'h22;
  localparam logic [7:0] CommaByte = 8'h2C;
  localparam logic [7:0] TabByte   = 8'd9;
  localparam logic [7:0] CrByte    = 8'd13;
  localparam logic [7:0] SpaceByte = 8'd32;

  typedef struct packed {
    logic [7:0] char_code;
    logic       line_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       char_valid;
    logic       field_end;
    logic       row_end;
    logic       space_dropped;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_EMIT,
    ACT_FLUSH
  } act_e;

  typedef struct packed {
    logic take;
    logic emit_held;
    logic emit_pend;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic flush_done;
    logic out_free;
  } sts_t;

endpackage

[hw/rtl/cfs_ctrl.sv]
`timescale 1ns / 1ps

module cfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cfs_pkg::sts_t sts_i,
  output cfs_pkg::cmd_t cmd_o
);
  import cfs_pkg::*;

  localparam logic StIdle  = 1'b0;
  localparam logic StFlush = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o          = '0;
    case (state_q)
      StIdle: begin
        in_ready_o = sts_i.out_free;
        cmd_o.take = in_valid_i & sts_i.out_free;
        if (cmd_o.take && sts_i.act == ACT_FLUSH) begin
          state_d = StFlush;
        end
      end
      StFlush: begin
        // Read out held whitespace, then the byte that released it
        if (sts_i.out_free) begin
          if (sts_i.flush_done) begin
            cmd_o.emit_pend = 1'b1;
            state_d         = StIdle;
          end else begin
            cmd_o.emit_held = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[hw/rtl/cfs_datapath.sv]
`timescale 1ns / 1ps

module cfs_datapath #(
  parameter int unsigned SPACE_HOLD_DEPTH = cfs_pkg::SpaceHoldDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfs_pkg::in_item_t  in_data_i,
  input  cfs_pkg::cmd_t      cmd_i,
  output cfs_pkg::sts_t      sts_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfs_pkg::out_item_t out_data_o
);
  import cfs_pkg::*;

  localparam int unsigned HoldDepth =
      (SPACE_HOLD_DEPTH < HoldSlots) ? SPACE_HOLD_DEPTH : HoldSlots;
  localparam int unsigned IdxW = (HoldDepth > 1) ? $clog2(HoldDepth) : 1;
  localparam logic [HoldCntW-1:0] HoldLimit = HoldCntW'(HoldDepth);

  logic                quoted_q, pending_q, seen_q, ovf_q;
  logic [HoldCntW-1:0] cnt_q, idx_q;
  logic [7:0]          held_q [HoldDepth];
  logic [7:0]          pend_char_q;
  logic                pend_sd_q;
  logic                out_valid_q;
  out_item_t           out_q;

  logic                quoted_d, pending_d, seen_d, ovf_d;
  logic [HoldCntW-1:0] cnt_d;
  out_item_t           out_d;
  logic                wr_en, content, is_space;
  act_e                act;
  out_item_t           res;
  logic [7:0]          c;

  assign c        = in_data_i.char_code;
  assign is_space = (c == SpaceByte) || (c inside {[TabByte:CrByte]});

  always_comb begin
    quoted_d  = quoted_q;
    pending_d = pending_q;
    seen_d    = seen_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    wr_en     = 1'b0;
    content   = 1'b0;
    act       = ACT_NONE;
    res       = '0;
    res.last  = 1'b1;
    if (in_data_i.line_end) begin
      act           = ACT_EMIT;
      res.field_end = 1'b1;
      res.row_end   = 1'b1;
      quoted_d      = 1'b0;
      pending_d     = 1'b0;
      seen_d        = 1'b0;
      cnt_d         = '0;
      ovf_d         = 1'b0;
    end else begin
      if (pending_q && c == QuoteByte) begin
        // Doubled quote: one literal quote, stay quoted
        pending_d = 1'b0;
        content   = 1'b1;
      end else begin
        if (pending_q) begin
          pending_d = 1'b0;
          quoted_d  = 1'b0;
        end
        if (c == QuoteByte) begin
          if (quoted_d) begin
            pending_d = 1'b1;
          end else begin
            quoted_d = 1'b1;
          end
        end else if (c == CommaByte && !quoted_d) begin
          act           = ACT_EMIT;
          res.field_end = 1'b1;
          seen_d        = 1'b0;
          cnt_d         = '0;
          ovf_d         = 1'b0;
        end else begin
          content = 1'b1;
        end
      end
      if (content) begin
        if (is_space) begin
          // Drop leading whitespace; hold trailing candidates
          if (seen_q) begin
            if (cnt_q < HoldLimit) begin
              wr_en = 1'b1;
              cnt_d = cnt_q + HoldCntW'(1);
            end else begin
              ovf_d = 1'b1;
            end
          end
        end else begin
          seen_d            = 1'b1;
          ovf_d             = 1'b0;
          res.out_char      = c;
          res.char_valid    = 1'b1;
          res.space_dropped = ovf_q;
          act               = (cnt_q == '0) ? ACT_EMIT : ACT_FLUSH;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quoted_q  <= 1'b0;
      pending_q <= 1'b0;
      seen_q    <= 1'b0;
      ovf_q     <= 1'b0;
      cnt_q     <= '0;
      idx_q     <= '0;
    end else if (cmd_i.take) begin
      quoted_q  <= quoted_d;
      pending_q <= pending_d;
      seen_q    <= seen_d;
      ovf_q     <= ovf_d;
      cnt_q     <= cnt_d;
      idx_q     <= '0;
    end else if (cmd_i.emit_held) begin
      idx_q <= idx_q + HoldCntW'(1);
    end else if (cmd_i.emit_pend) begin
      cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && wr_en) begin
      held_q[cnt_q[IdxW-1:0]] <= c;
    end
    if (cmd_i.take && act == ACT_FLUSH) begin
      pend_char_q <= c;
      pend_sd_q   <= ovf_q;
    end
  end

  // Output register: holds a result until transferred
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.take && act == ACT_EMIT) || cmd_i.emit_held || cmd_i.emit_pend) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_d = out_q;
    if (cmd_i.take && act == ACT_EMIT) begin
      out_d = res;
    end else if (cmd_i.emit_held || cmd_i.emit_pend) begin
      out_d               = '0;
      out_d.out_char      = cmd_i.emit_held ? held_q[idx_q[IdxW-1:0]] : pend_char_q;
      out_d.char_valid    = 1'b1;
      out_d.space_dropped = pend_sd_q;
      out_d.last          = cmd_i.emit_pend;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign sts_o.act        = act;
  assign sts_o.flush_done = (idx_q == cnt_q);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;
  assign out_valid_o      = out_valid_q;
  assign out_data_o       = out_q;

endmodule

[hw/rtl/csv_field_splitter.sv]
`timescale 1ns / 1ps

// CSV field splitter: takes one line byte (or a line-end marker) per transfer
// and returns the trimmed bytes of each comma-separated field, a field-end
// result per unquoted comma and a row-end result per line end, with quote
// handling including doubled quotes. A new item is normally taken in the
// cycle the previous result leaves the output register. A non-space byte
// that follows N held trailing-space bytes (N up to min(SPACE_HOLD_DEPTH,
// 15)) is taken first, then each held byte is read out of the store in
// turn, then the byte itself; input ready is low meanwhile, and each
// read-out waits until the output register is free.
module csv_field_splitter #(
  parameter int unsigned SPACE_HOLD_DEPTH = cfs_pkg::SpaceHoldDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cfs_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cfs_pkg::out_item_t out_data_o
);
  import cfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cfs_datapath #(
    .SPACE_HOLD_DEPTH (SPACE_HOLD_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[tb/tb_csv_field_splitter.sv]
`timescale 1ns / 1ps

class split_scoreboard;
  cfs_pkg::out_item_t field_results_q[$];
  bit                 in_quotes;
  bit                 quote_held;
  bit                 field_open;
  logic [7:0]         held_ws[cfs_pkg::HoldSlots];
  int unsigned        held_n;
  int unsigned        hold_limit;
  bit                 ws_lost;
  int unsigned        errors;
  int unsigned        checked;
  int unsigned        rows;
  int unsigned        lossy;

  function new();
    hold_limit = (cfs_pkg::SpaceHoldDepthDef < cfs_pkg::HoldSlots) ?
                 cfs_pkg::SpaceHoldDepthDef : cfs_pkg::HoldSlots;
    in_quotes  = 1'b0;
    quote_held = 1'b0;
    errors     = 0;
    checked    = 0;
    rows       = 0;
    lossy      = 0;
    clear_field();
  endfunction

  function bit is_ws(logic [7:0] c);
    return c == cfs_pkg::SpaceByte || (c >= cfs_pkg::TabByte && c <= cfs_pkg::CrByte);
  endfunction

  function void clear_field();
    field_open = 1'b0;
    held_n     = 0;
    ws_lost    = 1'b0;
  endfunction

  function void push(logic [7:0] c, bit is_char, bit fe, bit re, bit sd);
    cfs_pkg::out_item_t r;
    r.out_char      = c;
    r.char_valid    = is_char;
    r.field_end     = fe;
    r.row_end       = re;
    r.space_dropped = sd;
    r.last          = 1'b0;
    field_results_q.push_back(r);
  endfunction

  // Hold trailing whitespace; a later non-space byte flushes it ahead of itself
  function void content_byte(logic [7:0] c);
    bit          sd;
    int unsigned i;
    if (is_ws(c)) begin
      if (!field_open) return;
      if (held_n < hold_limit) begin
        held_ws[held_n] = c;
        held_n++;
      end else begin
        ws_lost = 1'b1;
      end
      return;
    end
    sd = ws_lost;
    for (i = 0; i < held_n; i++) push(held_ws[i], 1'b1, 1'b0, 1'b0, sd);
    push(c, 1'b1, 1'b0, 1'b0, sd);
    held_n     = 0;
    ws_lost    = 1'b0;
    field_open = 1'b1;
  endfunction

  function void take_item(cfs_pkg::in_item_t it);
    int unsigned start_n;
    bit          done;
    start_n = field_results_q.size();
    done    = 1'b0;
    if (it.line_end) begin
      push(8'h00, 1'b0, 1'b1, 1'b1, 1'b0);
      in_quotes  = 1'b0;
      quote_held = 1'b0;
      clear_field();
    end else begin
      if (quote_held) begin
        quote_held = 1'b0;
        if (it.char_code == cfs_pkg::QuoteByte) begin
          content_byte(it.char_code);
          done = 1'b1;
        end else begin
          in_quotes = 1'b0;
        end
      end
      if (!done) begin
        if (it.char_code == cfs_pkg::QuoteByte) begin
          if (in_quotes) quote_held = 1'b1;
          else in_quotes = 1'b1;
        end else if (it.char_code == cfs_pkg::CommaByte && !in_quotes) begin
          push(8'h00, 1'b0, 1'b1, 1'b0, 1'b0);
          clear_field();
        end else begin
          content_byte(it.char_code);
        end
      end
    end
    if (field_results_q.size() > start_n)
      field_results_q[field_results_q.size() - 1].last = 1'b1;
  endfunction

  function void mismatch(string what, int unsigned e, int unsigned a);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, e, a);
  endfunction

  function void check_out(cfs_pkg::out_item_t got);
    cfs_pkg::out_item_t want;
    if (field_results_q.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, got %h", $time, got);
      return;
    end
    want = field_results_q.pop_front();
    checked++;
    if (want.row_end) rows++;
    if (want.space_dropped) lossy++;
    if (got.out_char !== want.out_char) mismatch("out_char", want.out_char, got.out_char);
    if (got.char_valid !== want.char_valid)
      mismatch("char_valid", want.char_valid, got.char_valid);
    if (got.field_end !== want.field_end) mismatch("field_end", want.field_end, got.field_end);
    if (got.row_end !== want.row_end) mismatch("row_end", want.row_end, got.row_end);
    if (got.space_dropped !== want.space_dropped)
      mismatch("space_dropped", want.space_dropped, got.space_dropped);
    if (got.last !== want.last) mismatch("last", want.last, got.last);
  endfunction
endclass

module tb_csv_field_splitter;

  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned ItemTarget = 300;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  cfs_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  cfs_pkg::out_item_t out_data;

  split_scoreboard sb = new();

  int unsigned idle_cycles = 0;
  int unsigned rx_cycle    = 0;
  int unsigned hold_left   = 0;
  int unsigned hold_asked  = 0;
  int unsigned hold_done   = 0;
  int unsigned burst_left  = 0;
  int unsigned items_sent  = 0;

  csv_field_splitter u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("tb_csv_field_splitter: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: check each transfer, then pick the next ready value
  always @(posedge clk) begin
    if (out_valid && out_ready) sb.check_out(out_data);
    rx_cycle <= rx_cycle + 1;
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= LongHold;
      out_ready <= 1'b0;
    end else begin
      case (rx_cycle[7:6])
        2'd0: out_ready <= 1'b1;
        2'd1: out_ready <= 1'($urandom_range(0, 1));
        2'd2: out_ready <= (rx_cycle[1:0] == 2'd0);
        default: out_ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  task automatic send_item(cfs_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? $urandom_range(1, 8) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.take_item(it);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] c);
    cfs_pkg::in_item_t it;
    it.char_code = c;
    it.line_end  = 1'b0;
    send_item(it);
  endtask

  task automatic send_end(logic [7:0] c);
    cfs_pkg::in_item_t it;
    it.char_code = c;
    it.line_end  = 1'b1;
    send_item(it);
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.field_results_q.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_ws();
    int unsigned r;
    r = $urandom_range(0, 6);
    return (r < 5) ? cfs_pkg::TabByte + r[7:0] : cfs_pkg::SpaceByte;
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == cfs_pkg::QuoteByte || c == cfs_pkg::CommaByte || sb.is_ws(c));
    return c;
  endfunction

  task automatic send_ws(int unsigned n);
    repeat (n) send_byte(rand_ws());
  endtask

  task automatic send_text(int unsigned n);
    repeat (n) send_byte(rand_text());
  endtask

  task automatic send_field();
    int unsigned kind;
    int unsigned r;
    kind = $urandom_range(0, 9);
    if (kind <= 2) begin
      send_text($urandom_range(0, 6));
    end else if (kind <= 5) begin
      send_ws($urandom_range(0, 3));
      send_text($urandom_range(1, 3));
      // long runs (12 to 20 bytes) can push the held whitespace past its depth
      send_ws(kind == 5 ? $urandom_range(12, 20) : $urandom_range(0, 4));
      send_text($urandom_range(1, 3));
      send_ws($urandom_range(0, 3));
    end else if (kind <= 7) begin
      send_ws($urandom_range(0, 1));
      send_byte(cfs_pkg::QuoteByte);
      repeat ($urandom_range(1, 6)) begin
        r = $urandom_range(0, 5);
        if (r == 0) begin
          send_byte(cfs_pkg::QuoteByte);
          send_byte(cfs_pkg::QuoteByte);
        end else if (r == 1) begin
          send_byte(cfs_pkg::CommaByte);
        end else if (r == 2) begin
          send_byte(rand_ws());
        end else begin
          send_byte(rand_text());
        end
      end
      send_byte(cfs_pkg::QuoteByte);
      send_text($urandom_range(0, 1));
      send_ws($urandom_range(0, 2));
    end else begin
      repeat ($urandom_range(1, 5))
        send_byte($urandom_range(0, 3) == 0 ? cfs_pkg::QuoteByte : 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_line();
    int unsigned nf;
    nf = $urandom_range(1, 4);
    for (int unsigned f = 0; f < nf; f++) begin
      send_field();
      if (f + 1 < nf) send_byte(cfs_pkg::CommaByte);
    end
    send_end(8'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned lines;
    bit          hold_sent;
    bit          paused;
    lines     = 0;
    hold_sent = 1'b0;
    paused    = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty line, with every bit of the ignored byte set
    send_end(8'hFF);
    // leading whitespace dropped, inner whitespace flushed
    send_byte(cfs_pkg::SpaceByte);
    send_byte(cfs_pkg::TabByte);
    send_byte(8'h61);
    send_byte(cfs_pkg::CrByte);
    send_byte(cfs_pkg::SpaceByte);
    send_byte(8'h62);
    send_byte(cfs_pkg::CommaByte);
    // comma inside quotes, doubled quote, closing quote followed by content
    send_byte(cfs_pkg::QuoteByte);
    send_byte(cfs_pkg::CommaByte);
    send_byte(cfs_pkg::QuoteByte);
    send_byte(cfs_pkg::QuoteByte);
    send_byte(cfs_pkg::QuoteByte);
    send_byte(8'h00);
    send_byte(8'h80);
    send_byte(8'hFF);
    send_byte(8'd10);
    send_byte(8'd11);
    send_byte(8'd12);
    send_byte(8'h7F);
    // trailing whitespace at line end goes without a flag
    send_byte(cfs_pkg::SpaceByte);
    send_end(8'h00);
    // quote held when the line ends
    send_byte(cfs_pkg::QuoteByte);
    send_byte(8'h41);
    send_byte(cfs_pkg::QuoteByte);
    send_end(8'h22);
    // quotes left open at line end
    send_byte(cfs_pkg::QuoteByte);
    send_byte(8'h78);
    send_end(8'h2C);
    lines = 4;

    while (items_sent < ItemTarget) begin
      send_line();
      lines++;
      if (!hold_sent && items_sent > 100) begin
        hold_asked <= hold_asked + 1;
        hold_sent = 1'b1;
      end
      if (!paused && items_sent > 200) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (20) @(posedge clk);

    $display("run: %0d items over %0d lines, %0d results checked, %0d rows closed",
             items_sent, lines, sb.checked, sb.rows);
    $display("run: %0d flushed bytes carried the dropped-whitespace flag", sb.lossy);
    if (sb.errors == 0 && sb.field_results_q.size() == 0) begin
      $display("tb_csv_field_splitter: done, clean");
    end else begin
      $display("tb_csv_field_splitter: done, errors");
    end
    $finish;
  end

endmodule

[csv_field_splitter.f]
hw/rtl/cfs_pkg.sv
hw/rtl/cfs_ctrl.sv
hw/rtl/cfs_datapath.sv
hw/rtl/csv_field_splitter.sv
tb/tb_csv_field_splitter.sv
